// ===== rtl/core/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
// Standalone package; no dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int IN_W  = 48;
    localparam int OUT_W = 32;

    localparam logic [2:0] OP_PUT   = 3'd0;
    localparam logic [2:0] OP_CLEAR = 3'd1;
    localparam logic [2:0] OP_MOVE  = 3'd2;
    localparam logic [2:0] OP_COLOR = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;

    localparam int TAB_STEP = 8;

    localparam logic [3:0] FG_RESET = 4'd15;
    localparam logic [3:0] BG_RESET = 4'd0;

    typedef struct packed {
        logic [1:0]  pad;
        logic [10:0] cell_index;
        logic [3:0]  bg_in;
        logic [3:0]  fg_in;
        logic [7:0]  row_in;
        logic [7:0]  col_in;
        logic [7:0]  char_code;
        logic [2:0]  op;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  pad;
        logic [15:0] cell_data;
        logic [10:0] cursor_pos;
    } out_item_t;

endpackage

// ===== rtl/core/text_console_writer.sv =====
// Text console writer: screen memory, cursor and color state, one result per transfer.
// Depends on tcw_pkg.
// Flow: ST_DONE loads the result once the output is free; before it, a scroll runs
//   a row copy through the registered read port, then a bottom row fill, and a clear
//   runs a clearing pass. One item in flight at a time: input is taken only when idle.
// After reset a clearing pass zeroes every screen cell with s_axis_tready low.
`timescale 1ns / 1ps

module text_console_writer #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // op, char_code, col_in, row_in, fg_in, bg_in, cell_index, zero pad
    input  logic [tcw_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // cursor_pos, cell_data, zero pad
    output logic [tcw_pkg::OUT_W-1:0]   m_axis_tdata
);
    import tcw_pkg::*;

    localparam int CELLS = COLS * ROWS;
    localparam int AW    = $clog2(CELLS);

    typedef enum logic [4:0] {
        ST_CLR    = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_SCROLL = 5'b00100,
        ST_FILL   = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    logic [AW-1:0] scan_reg, scan_next;
    logic        clr_op_reg, clr_op_next;
    logic [15:0] fill_reg, fill_next;
    logic [7:0]  cursor_col_reg, cursor_col_next;
    logic [7:0]  cursor_row_reg, cursor_row_next;
    logic [3:0]  fore_reg, fore_next;
    logic [3:0]  back_reg, back_next;
    logic        rd_ok_reg, rd_ok_next;
    logic        cp_vld_reg, cp_vld_next;
    logic [AW-1:0] cp_addr_reg, cp_addr_next;
    logic        m_valid_reg;
    out_item_t   m_data_reg;

    logic [15:0] mem [CELLS];
    logic [15:0] rdata_reg;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [15:0]   mem_wd;

    in_item_t    item;
    logic        accept;
    logic        out_free;
    logic [15:0] lin;
    logic [8:0]  nc_col, nc_row, tab_sum, row_wrap;
    logic        printable, col_wrap, scroll;
    logic [7:0]  nrm_col, nrm_row;

    assign item          = in_item_t'(s_axis_tdata);
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    assign lin       = 16'(cursor_row_reg) * 16'(COLS) + 16'(cursor_col_reg);
    assign printable = (item.char_code >= CH_SPACE);
    assign tab_sum   = {1'b0, cursor_col_reg} + 9'(TAB_STEP);

    // Proposed cursor before normalization
    always_comb
    begin
        nc_col = {1'b0, cursor_col_reg};
        nc_row = {1'b0, cursor_row_reg};
        if (item.op == OP_PUT)
        begin
            case (item.char_code)
                CH_BS:
                begin
                    if (cursor_col_reg != 8'd0)
                        nc_col = {1'b0, cursor_col_reg} - 9'd1;
                end
                CH_TAB: nc_col = tab_sum & ~9'(TAB_STEP - 1);
                CH_CR:  nc_col = 9'd0;
                CH_LF:
                begin
                    nc_col = 9'd0;
                    nc_row = {1'b0, cursor_row_reg} + 9'd1;
                end
                default:
                begin
                    if (printable)
                        nc_col = {1'b0, cursor_col_reg} + 9'd1;
                end
            endcase
        end
        else if (item.op == OP_MOVE)
        begin
            nc_col = {1'b0, item.col_in};
            nc_row = {1'b0, item.row_in};
        end
    end

    assign col_wrap = (nc_col >= 9'(COLS));
    assign row_wrap = col_wrap ? nc_row + 9'd1 : nc_row;
    assign scroll   = (row_wrap >= 9'(ROWS));
    assign nrm_col  = col_wrap ? 8'd0 : nc_col[7:0];
    assign nrm_row  = scroll ? 8'(ROWS - 1) : row_wrap[7:0];

    // Memory port selection
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = '0;
        mem_re = 1'b0;
        mem_ra = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && item.op == OP_PUT && printable)
                begin
                    mem_we = 1'b1;
                    mem_wa = AW'(lin);
                    mem_wd = {back_reg, fore_reg, item.char_code};
                end
                if (accept && item.op == OP_READ && 17'(item.cell_index) < 17'(CELLS))
                begin
                    mem_re = 1'b1;
                    mem_ra = AW'(item.cell_index);
                end
            end
            ST_CLR:
            begin
                mem_we = 1'b1;
                mem_wa = scan_reg;
                mem_wd = clr_op_reg ? fill_reg : 16'd0;
            end
            ST_SCROLL:
            begin
                mem_re = 1'b1;
                mem_ra = scan_reg + AW'(COLS);
                if (cp_vld_reg)
                begin
                    mem_we = 1'b1;
                    mem_wa = cp_addr_reg;
                    mem_wd = rdata_reg;
                end
            end
            ST_FILL:
            begin
                mem_we = 1'b1;
                if (cp_vld_reg)
                begin
                    mem_wa = cp_addr_reg;
                    mem_wd = rdata_reg;
                end
                else
                begin
                    mem_wa = scan_reg;
                    mem_wd = {back_reg, fore_reg, CH_SPACE};
                end
            end
            ST_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (mem_re)
            rdata_reg <= mem[mem_ra];
    end

    always_comb
    begin
        state_next      = state_reg;
        scan_next       = scan_reg;
        clr_op_next     = clr_op_reg;
        fill_next       = fill_reg;
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        fore_next       = fore_reg;
        back_next       = back_reg;
        rd_ok_next      = rd_ok_reg;
        cp_vld_next     = 1'b0;
        cp_addr_next    = cp_addr_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rd_ok_next = mem_re;
                    scan_next  = '0;
                    state_next = ST_DONE;
                    case (item.op) inside
                        OP_PUT, OP_MOVE:
                        begin
                            cursor_col_next = nrm_col;
                            cursor_row_next = nrm_row;
                            if (scroll)
                                state_next = ST_SCROLL;
                        end
                        OP_CLEAR:
                        begin
                            fill_next       = {item.bg_in, item.fg_in, item.char_code};
                            fore_next       = item.fg_in;
                            back_next       = item.bg_in;
                            cursor_col_next = 8'd0;
                            cursor_row_next = 8'd0;
                            clr_op_next     = 1'b1;
                            state_next      = ST_CLR;
                        end
                        OP_COLOR:
                        begin
                            fore_next = item.fg_in;
                            back_next = item.bg_in;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CLR:
            begin
                if (scan_reg == AW'(CELLS - 1))
                begin
                    scan_next  = '0;
                    state_next = clr_op_reg ? ST_DONE : ST_IDLE;
                end
                else
                    scan_next = scan_reg + AW'(1);
            end
            ST_SCROLL:
            begin
                cp_vld_next  = 1'b1;
                cp_addr_next = scan_reg;
                if (scan_reg == AW'(CELLS - COLS - 1))
                begin
                    scan_next  = AW'(CELLS - COLS);
                    state_next = ST_FILL;
                end
                else
                    scan_next = scan_reg + AW'(1);
            end
            ST_FILL:
            begin
                if (!cp_vld_reg)
                begin
                    if (scan_reg == AW'(CELLS - 1))
                        state_next = ST_DONE;
                    else
                        scan_next = scan_reg + AW'(1);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLR;
            scan_reg       <= '0;
            clr_op_reg     <= 1'b0;
            cursor_col_reg <= 8'd0;
            cursor_row_reg <= 8'd0;
            fore_reg       <= FG_RESET;
            back_reg       <= BG_RESET;
            rd_ok_reg      <= 1'b0;
            cp_vld_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_reg       <= scan_next;
            clr_op_reg     <= clr_op_next;
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
            fore_reg       <= fore_next;
            back_reg       <= back_next;
            rd_ok_reg      <= rd_ok_next;
            cp_vld_reg     <= cp_vld_next;
            if (state_reg == ST_DONE && out_free)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_reg    <= fill_next;
        cp_addr_reg <= cp_addr_next;
        if (state_reg == ST_DONE && out_free)
        begin
            m_data_reg.pad        <= '0;
            m_data_reg.cell_data  <= rd_ok_reg ? rdata_reg : 16'd0;
            m_data_reg.cursor_pos <= lin[10:0];
        end
    end

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cursor_col_reg < 8'(COLS)) && (cursor_row_reg < 8'(ROWS)))
        else $error("cursor out of screen");

    a_copy_state: assert property (@(posedge clk) disable iff (!rst_n)
        cp_vld_reg |-> (state_reg == ST_SCROLL || state_reg == ST_FILL))
        else $error("row copy write outside scroll");

    a_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && mem_we) |-> (accept && item.op == OP_PUT))
        else $error("screen write while idle without put char");

    a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free) |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("result not loaded");

endmodule
